// ===== rtl/svg_pkg.sv =====
package svg_pkg;

	localparam int MAX_DIVISIONS_DEF = 1024;
	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int CFG_W             = 11;
	localparam int IDX_W             = 10;
	localparam int POS_W             = 16;
	localparam int TEX_W             = 16;
	localparam int ANG_W             = 32;
	localparam int CW                = 34;
	localparam int ATAN_LEN          = 24;
	localparam logic [CW-1:0] CORDIC_X0 = CW'(652032874);
	localparam logic [CW-1:0] ONE_Q30   = CW'(1 << 30);

	localparam logic [0:0] REG_SECTOR_COUNT = 1'b0;
	localparam logic [0:0] REG_STACK_COUNT  = 1'b1;

	localparam logic [CFG_W-1:0] SECTOR_COUNT_RST = CFG_W'(36);
	localparam logic [CFG_W-1:0] STACK_COUNT_RST  = CFG_W'(18);

	function automatic logic [31:0] atan_turns(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
			3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
			9: r = 32'h00145F2F;  10: r = 32'h000A2F98; 11: r = 32'h000517CC;
			12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
			15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
			18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
			21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/svg_stream_if.sv =====
interface svg_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/svg_divider.sv =====
// Pipelined restoring divider: quotient = floor(num * 2^QW / den), num < den.
// One quotient bit per stage; sideband rides along with the data.
module svg_divider #(
	parameter int NUM_W = 16,
	parameter int QW    = 32,
	parameter int SB_W  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [NUM_W-1:0] den,
	input  logic [SB_W-1:0]  in_sb,
	output logic             out_valid,
	output logic [QW-1:0]    quo,
	output logic [SB_W-1:0]  out_sb
);
	logic             v_s   [QW+1];
	logic [NUM_W:0]   rem_s [QW+1];
	logic [NUM_W-1:0] den_s [QW+1];
	logic [QW-1:0]    q_s   [QW+1];
	logic [SB_W-1:0]  sb_s  [QW+1];

	always_comb begin
		v_s[0]   = in_valid;
		rem_s[0] = {1'b0, num};
		den_s[0] = den;
		q_s[0]   = '0;
		sb_s[0]  = in_sb;
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [NUM_W+1:0] shifted;
		logic [NUM_W+1:0] diff;
		assign shifted = {rem_s[k], 1'b0};
		assign diff    = shifted - {2'b00, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1] <= den_s[k];
				sb_s[k+1]  <= sb_s[k];
				if (!diff[NUM_W+1]) begin
					rem_s[k+1] <= diff[NUM_W:0];
					q_s[k+1]   <= {q_s[k][QW-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= shifted[NUM_W:0];
					q_s[k+1]   <= {q_s[k][QW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo       = q_s[QW];
	assign out_sb    = sb_s[QW];
endmodule

// ===== rtl/svg_cordic.sv =====
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, with
// quadrant fold and saturation at the end. Outputs cos, sin in Q30.
module svg_cordic #(
	parameter int STEPS = svg_pkg::CORDIC_STEPS_DEF,
	parameter int SB_W  = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [svg_pkg::ANG_W-1:0]   ang,
	input  logic [SB_W-1:0]             in_sb,
	output logic                        out_valid,
	output logic signed [svg_pkg::CW-1:0] cos_o,
	output logic signed [svg_pkg::CW-1:0] sin_o,
	output logic [SB_W-1:0]             out_sb
);
	localparam int CW = svg_pkg::CW;

	logic                 v_s [STEPS+1];
	logic signed [CW-1:0] x_s [STEPS+1];
	logic signed [CW-1:0] y_s [STEPS+1];
	logic signed [CW-1:0] z_s [STEPS+1];
	logic [1:0]           q_s [STEPS+1];
	logic [SB_W-1:0]      sb_s [STEPS+1];

	always_comb begin
		v_s[0]  = in_valid;
		x_s[0]  = svg_pkg::CORDIC_X0;
		y_s[0]  = '0;
		z_s[0]  = CW'(ang[29:0]);
		q_s[0]  = ang[31:30];
		sb_s[0] = in_sb;
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_rot
		logic signed [CW-1:0] dx, dy, at;
		assign dx = y_s[k] >>> k;
		assign dy = x_s[k] >>> k;
		assign at = CW'(svg_pkg::atan_turns(k));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1]  <= q_s[k];
				sb_s[k+1] <= sb_s[k];
				if (!z_s[k][CW-1]) begin
					x_s[k+1] <= x_s[k] - dx;
					y_s[k+1] <= y_s[k] + dy;
					z_s[k+1] <= z_s[k] - at;
				end else begin
					x_s[k+1] <= x_s[k] + dx;
					y_s[k+1] <= y_s[k] - dy;
					z_s[k+1] <= z_s[k] + at;
				end
			end
		end
	end

	logic signed [CW-1:0] xc, yc;
	always_comb begin
		xc = x_s[STEPS];
		if (xc > $signed(svg_pkg::ONE_Q30)) xc = svg_pkg::ONE_Q30;
		if (xc < -$signed(svg_pkg::ONE_Q30)) xc = -svg_pkg::ONE_Q30;
		yc = y_s[STEPS];
		if (yc > $signed(svg_pkg::ONE_Q30)) yc = svg_pkg::ONE_Q30;
		if (yc < -$signed(svg_pkg::ONE_Q30)) yc = -svg_pkg::ONE_Q30;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_sb <= sb_s[STEPS];
			case (q_s[STEPS])
				2'd0: begin cos_o <= xc;  sin_o <= yc;  end
				2'd1: begin cos_o <= -yc; sin_o <= xc;  end
				2'd2: begin cos_o <= -xc; sin_o <= -yc; end
				default: begin cos_o <= yc; sin_o <= -xc; end
			endcase
		end
	end
endmodule

// ===== rtl/svg_combine.sv =====
// Final products, rounding and saturation to Q1.14: multiply stage, then round stage.
module svg_combine #(
	parameter int SB_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [svg_pkg::CW-1:0] cphi,
	input  logic signed [svg_pkg::CW-1:0] sphi,
	input  logic signed [svg_pkg::CW-1:0] cth,
	input  logic signed [svg_pkg::CW-1:0] sth,
	input  logic [SB_W-1:0]               in_sb,
	output logic                          out_valid,
	output logic signed [svg_pkg::POS_W-1:0] px,
	output logic signed [svg_pkg::POS_W-1:0] py,
	output logic signed [svg_pkg::POS_W-1:0] pz,
	output logic [SB_W-1:0]               out_sb
);
	localparam int CW = svg_pkg::CW;
	localparam int PW = 2 * CW;

	logic                 v_s1;
	logic signed [PW-1:0] mx_s1, my_s1;
	logic signed [CW-1:0] cz_s1;
	logic [SB_W-1:0]      sb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= PW'(sphi) * PW'(cth);
			my_s1 <= PW'(sphi) * PW'(sth);
			cz_s1 <= cphi;
			sb_s1 <= in_sb;
		end
	end

	function automatic logic signed [svg_pkg::POS_W-1:0] sat(input logic signed [PW-1:0] v);
		logic signed [svg_pkg::POS_W-1:0] r;
		if (v > PW'(16384)) r = 16'sd16384;
		else if (v < -PW'(16384)) r = -16'sd16384;
		else r = v[svg_pkg::POS_W-1:0];
		return r;
	endfunction

	logic signed [PW-1:0] rx, ry, rz;
	always_comb begin
		rx = (mx_s1 + (PW'(1) <<< 45)) >>> 46;
		ry = (my_s1 + (PW'(1) <<< 45)) >>> 46;
		rz = (PW'(cz_s1) + PW'(32768)) >>> 16;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px     <= sat(rx);
			py     <= sat(ry);
			pz     <= sat(rz);
			out_sb <= sb_s1;
		end
	end
endmodule

// ===== rtl/sphere_vertex_generator.sv =====
// UV-sphere vertex generator. Each item carries (sector_index, stack_index);
// one result item with pos_x/y/z (Q1.14) and tex_u/v (Q0.16) comes back
// per item, in order. One item enters per cycle while the output is not
// stalled. The pipeline is the clamp stage, 32 restoring angle divider
// stages (one quotient bit each), CORDIC_STEPS rotation stages, quadrant
// fold, product and rounding stages. A stall on the output freezes the whole
// pipeline; the last stage is the output register. Counts of 0 act as 1 and
// counts above MAX_DIVISIONS act as MAX_DIVISIONS; indexes clamp to
// count - 1. Write sector_count / stack_count only while the block is idle.
module sphere_vertex_generator #(
	parameter int MAX_DIVISIONS = svg_pkg::MAX_DIVISIONS_DEF,
	parameter int CORDIC_STEPS  = svg_pkg::CORDIC_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [svg_pkg::CFG_W-1:0]  cfg_data,
	svg_stream_if.sink                 in_ch,
	svg_stream_if.source               out_ch
);
	localparam int CFG_W = svg_pkg::CFG_W;
	localparam int NW    = CFG_W + 1;
	localparam int TW    = svg_pkg::TEX_W;
	localparam int SB_W  = 2 * TW;

	logic [CFG_W-1:0] sector_count_q, stack_count_q;

	// Configuration registers; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_count_q <= svg_pkg::SECTOR_COUNT_RST;
			stack_count_q  <= svg_pkg::STACK_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				svg_pkg::REG_SECTOR_COUNT: sector_count_q <= cfg_data;
				svg_pkg::REG_STACK_COUNT:  stack_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// A cap at or above the register range never bites.
	function automatic logic [NW-1:0] eff(input logic [CFG_W-1:0] r);
		logic [NW-1:0] e;
		if (r == '0) e = NW'(1);
		else if (int'(r) > MAX_DIVISIONS) e = NW'(MAX_DIVISIONS);
		else e = NW'(r);
		return e;
	endfunction

	logic [NW-1:0] nsec, nstk;
	assign nsec = eff(sector_count_q);
	assign nstk = eff(stack_count_q);

	// The whole pipeline advances when the output register is empty or its result is taken.
	logic en;
	logic out_valid_q;
	assign en          = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en;

	// Stage 1: clamp indexes against the effective counts.
	logic          v_s1;
	logic [NW-1:0] sec_s1, stk_s1, nsec_s1, nstk_s1;
	logic [NW-1:0] sec_in, stk_in;
	assign sec_in = NW'(in_ch.data.sector_index);
	assign stk_in = NW'(in_ch.data.stack_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s1  <= (sec_in >= nsec) ? nsec - NW'(1) : sec_in;
			stk_s1  <= (stk_in >= nstk) ? nstk - NW'(1) : stk_in;
			nsec_s1 <= nsec;
			nstk_s1 <= nstk;
		end
	end

	// Angle dividers: phi = sec*2^32/nsec; theta = stk*2^31/nstk via
	// stk*2^32/(2*nstk). tex_u is phi quotient bits 31:16, tex_v is theta quotient bits 30:15.
	logic          dv_phi, dv_th;
	logic [31:0]   phi_q32, th_q32;
	logic [0:0]    unused_sb;

	svg_divider #(.NUM_W(NW + 1), .QW(32), .SB_W(1)) u_div_phi (
		.clk, .arst_n, .en,
		.in_valid (v_s1),
		.num      ({1'b0, sec_s1}),
		.den      ({1'b0, nsec_s1}),
		.in_sb    (1'b0),
		.out_valid(dv_phi),
		.quo      (phi_q32),
		.out_sb   (unused_sb)
	);

	logic [0:0] unused_sb2;
	svg_divider #(.NUM_W(NW + 1), .QW(32), .SB_W(1)) u_div_th (
		.clk, .arst_n, .en,
		.in_valid (v_s1),
		.num      ({1'b0, stk_s1}),
		.den      ({nstk_s1, 1'b0}),
		.in_sb    (1'b0),
		.out_valid(dv_th),
		.quo      (th_q32),
		.out_sb   (unused_sb2)
	);

	// tex_v = floor(stk*2^16/nstk) = top bits of stk*2^32/(2*nstk) shifted by 15.
	logic [SB_W-1:0] tex_sb;
	assign tex_sb = {phi_q32[31:16], th_q32[30:15]};

	logic                          cv_phi, cv_th;
	logic signed [svg_pkg::CW-1:0] cphi, sphi, cth, sth;
	logic [SB_W-1:0]               sb_c, sb_c2;

	svg_cordic #(.STEPS(CORDIC_STEPS), .SB_W(SB_W)) u_cordic_phi (
		.clk, .arst_n, .en,
		.in_valid (dv_phi),
		.ang      (phi_q32),
		.in_sb    (tex_sb),
		.out_valid(cv_phi),
		.cos_o    (cphi),
		.sin_o    (sphi),
		.out_sb   (sb_c)
	);

	svg_cordic #(.STEPS(CORDIC_STEPS), .SB_W(SB_W)) u_cordic_th (
		.clk, .arst_n, .en,
		.in_valid (dv_th),
		.ang      ({th_q32[30:0], 1'b0} >> 1),
		.in_sb    (tex_sb),
		.out_valid(cv_th),
		.cos_o    (cth),
		.sin_o    (sth),
		.out_sb   (sb_c2)
	);

	logic                               comb_v;
	logic signed [svg_pkg::POS_W-1:0]   px, py, pz;
	logic [SB_W-1:0]                    sb_o;

	svg_combine #(.SB_W(SB_W)) u_combine (
		.clk, .arst_n, .en,
		.in_valid (cv_phi && cv_th),
		.cphi, .sphi, .cth, .sth,
		.in_sb    (sb_c),
		.out_valid(comb_v),
		.px, .py, .pz,
		.out_sb   (sb_o)
	);

	assign out_valid_q       = comb_v;
	assign out_ch.valid      = comb_v;
	assign out_ch.data.pos_x = px;
	assign out_ch.data.pos_y = py;
	assign out_ch.data.pos_z = pz;
	assign out_ch.data.tex_u = sb_o[SB_W-1:TW];
	assign out_ch.data.tex_v = sb_o[TW-1:0];

	// Both angle lanes march in lockstep.
	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		cv_phi == cv_th) else $error("angle lanes out of step");
	a_tex_sync: assert property (@(posedge clk) disable iff (!arst_n)
		cv_phi |-> sb_c == sb_c2) else $error("texture sideband mismatch");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(px))
		else $error("stalled result changed");
endmodule
